### rtl/core/ppcc_pkg.sv
// ----------------------------------------------------------------------------
// ppcc_pkg
// Types, constants and the service port lookup of the packet classifier core.
// ----------------------------------------------------------------------------
package ppcc_pkg;

	localparam int NUM_CLASSES     = 7;
	localparam int PORTS_PER_CLASS = 5;

	localparam int TABLE_ROWS  = 7;
	localparam int TABLE_COLS  = 5;
	localparam int LOOKUP_ROWS = (NUM_CLASSES < TABLE_ROWS) ? NUM_CLASSES : TABLE_ROWS;
	localparam int LOOKUP_COLS = (PORTS_PER_CLASS < TABLE_COLS) ? PORTS_PER_CLASS : TABLE_COLS;

	localparam int CNT_W   = 32;
	localparam int BYTE_W  = 48;
	localparam int TIME_W  = 32;
	localparam int PORT_W  = 16;
	localparam int LEN_W   = 16;
	localparam int ETH_W   = 16;
	localparam int PROTO_W = 8;
	localparam int CODE_W  = 3;
	localparam int NUM_PROTO = 4;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic REG_CLASSIFY_EN = 1'b0;

	localparam logic [ETH_W-1:0]   ETH_IPV4   = 16'h0800;
	localparam logic [PROTO_W-1:0] PROTO_TCP  = 8'd6;
	localparam logic [PROTO_W-1:0] PROTO_UDP  = 8'd17;
	localparam logic [PROTO_W-1:0] PROTO_ICMP = 8'd1;

	localparam logic [PORT_W-1:0] VOIP_RANGE_LO = 16'd16384;
	localparam logic [PORT_W-1:0] VOIP_RANGE_HI = 16'd16482;
	localparam logic [PORT_W-1:0] GAME_RANGE_LO = 16'd27000;
	localparam logic [PORT_W-1:0] GAME_RANGE_HI = 16'd27050;

	typedef enum logic [CODE_W-1:0] {
		PC_TCP   = 3'd0,
		PC_UDP   = 3'd1,
		PC_ICMP  = 3'd2,
		PC_OTHER = 3'd3,
		PC_NONE  = 3'd4
	} proto_class_t;

	typedef enum logic [CODE_W-1:0] {
		TC_UNKNOWN  = 3'd0,
		TC_WEB      = 3'd1,
		TC_VIDEO    = 3'd2,
		TC_GAMING   = 3'd3,
		TC_VOIP     = 3'd4,
		TC_FILE     = 3'd5,
		TC_DATABASE = 3'd6
	} traffic_class_t;

	localparam logic [PORT_W-1:0] SVC_PORTS [TABLE_ROWS][TABLE_COLS] = '{
		'{16'd0,    16'd0,    16'd0,     16'd0,     16'd0},
		'{16'd80,   16'd443,  16'd8080,  16'd8443,  16'd0},
		'{16'd554,  16'd1935, 16'd5000,  16'd5001,  16'd0},
		'{16'd3074, 16'd3478, 16'd3658,  16'd27015, 16'd0},
		'{16'd5060, 16'd5061, 16'd16384, 16'd16397, 16'd0},
		'{16'd20,   16'd21,   16'd22,    16'd989,   16'd990},
		'{16'd1433, 16'd1521, 16'd3306,  16'd5432,  16'd0}
	};

	function automatic traffic_class_t port_lookup(input logic [PORT_W-1:0] port);
		logic           hit;
		traffic_class_t cls;
		hit = 1'b0;
		cls = TC_UNKNOWN;
		for (int r = 1; r < LOOKUP_ROWS; r++) begin
			for (int c = 0; c < LOOKUP_COLS; c++) begin
				if (!hit && SVC_PORTS[r][c] != '0 && port == SVC_PORTS[r][c]) begin
					hit = 1'b1;
					cls = traffic_class_t'(r[CODE_W-1:0]);
				end
			end
		end
		if (!hit) begin
			if (port >= VOIP_RANGE_LO && port <= VOIP_RANGE_HI) begin
				cls = (int'(TC_VOIP) < NUM_CLASSES) ? TC_VOIP : TC_UNKNOWN;
			end else if (port >= GAME_RANGE_LO && port <= GAME_RANGE_HI) begin
				cls = (int'(TC_GAMING) < NUM_CLASSES) ? TC_GAMING : TC_UNKNOWN;
			end
		end
		return cls;
	endfunction

endpackage

### rtl/core/ppcc_in_if.sv
// ----------------------------------------------------------------------------
// ppcc_in_if
// Header item channel: valid/ready with the extracted packet header fields.
// ----------------------------------------------------------------------------
interface ppcc_in_if;
	logic                          valid;
	logic                          ready;
	logic [ppcc_pkg::ETH_W-1:0]    ether_type;
	logic [ppcc_pkg::PROTO_W-1:0]  ip_proto;
	logic [ppcc_pkg::PORT_W-1:0]   source_port;
	logic [ppcc_pkg::PORT_W-1:0]   dest_port;
	logic [ppcc_pkg::LEN_W-1:0]    frame_length;
	logic [ppcc_pkg::TIME_W-1:0]   arrival_time;

	modport source (
		output valid, ether_type, ip_proto, source_port, dest_port, frame_length,
		arrival_time,
		input  ready
	);
	modport sink (
		input  valid, ether_type, ip_proto, source_port, dest_port, frame_length,
		arrival_time,
		output ready
	);
endinterface

### rtl/core/ppcc_out_if.sv
// ----------------------------------------------------------------------------
// ppcc_out_if
// Result item channel: valid/ready with the classification and counters.
// ----------------------------------------------------------------------------
interface ppcc_out_if;
	logic                          valid;
	logic                          ready;
	logic [ppcc_pkg::CODE_W-1:0]   proto_class;
	logic                          classified;
	logic [ppcc_pkg::CODE_W-1:0]   traffic_class;
	logic [ppcc_pkg::CODE_W-1:0]   dominant_class;
	logic [ppcc_pkg::CNT_W-1:0]    total_packet_count;
	logic [ppcc_pkg::CNT_W-1:0]    class_packet_count;

	modport source (
		output valid, proto_class, classified, traffic_class, dominant_class,
		total_packet_count, class_packet_count,
		input  ready
	);
	modport sink (
		input  valid, proto_class, classified, traffic_class, dominant_class,
		total_packet_count, class_packet_count,
		output ready
	);
endinterface

### rtl/core/packet_port_classifier_counters_core.sv
// ----------------------------------------------------------------------------
// packet_port_classifier_counters_core
// Per-packet protocol and port classification with traffic counters.
// ----------------------------------------------------------------------------
// usage:
//   pkt : one item per packet header (ethertype, ip protocol, ports, length,
//         arrival time), accepted when valid and ready are both high
//   res : one result item per header: protocol class, traffic type,
//         dominant type and updated packet counters
//   apb : register 0 at byte address 0 is classify_enable (bit 0, reset 1)
// path: the port lookup runs ahead of the input register, the counter
//   update and leader compare run between the input register and the
//   result register
// throughput: one item per cycle unless res is held; all counters are read
//   and written in the single update stage, so the next header sees this one's updates
// reset: all counters, the dominant type and the valid flags of both stages are cleared
// stall: while res is held, the result register and the input register
//   each keep one item; pkt ready drops only when both are full
// ----------------------------------------------------------------------------
module packet_port_classifier_counters_core (
	input  logic                                clk,
	input  logic                                arst_n,
	ppcc_in_if.sink                             pkt,
	ppcc_out_if.source                          res,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [ppcc_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [ppcc_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [ppcc_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready
);

	// configuration
	logic cls_en_q;
	logic cfg_wr;

	// input stage
	logic                             s1_v_q;
	logic                             ipv4_s1;
	logic                             do_cls_s1;
	ppcc_pkg::proto_class_t           pclass_s1;
	ppcc_pkg::traffic_class_t         tclass_s1;
	logic [ppcc_pkg::LEN_W-1:0]       flen_s1;
	logic [ppcc_pkg::TIME_W-1:0]      time_s1;

	// front classification
	ppcc_pkg::proto_class_t           pclass_in;
	ppcc_pkg::traffic_class_t         src_cls;
	ppcc_pkg::traffic_class_t         dst_cls;
	logic                             ipv4_in;
	logic                             accept;
	logic                             adv;
	logic                             fire;

	// counters
	logic [ppcc_pkg::CNT_W-1:0]       pkts_q;
	logic [ppcc_pkg::BYTE_W-1:0]      bytes_q;
	logic [ppcc_pkg::TIME_W-1:0]      prev_time_q;
	logic [ppcc_pkg::BYTE_W-1:0]      gap_total_q;
	logic [ppcc_pkg::CNT_W-1:0]       gap_samples_q;
	logic [ppcc_pkg::CNT_W-1:0]       proto_cnt_q [ppcc_pkg::NUM_PROTO];
	logic [ppcc_pkg::CNT_W-1:0]       cls_pkts_q [ppcc_pkg::NUM_CLASSES];
	logic [ppcc_pkg::BYTE_W-1:0]      cls_bytes_q [ppcc_pkg::NUM_CLASSES];
	logic [ppcc_pkg::CNT_W-1:0]       leader_cnt_q;
	ppcc_pkg::traffic_class_t         leader_cls_q;

	logic [ppcc_pkg::CNT_W-1:0]       pkts_nxt;
	logic [ppcc_pkg::CNT_W-1:0]       cls_cnt_nxt;
	logic [ppcc_pkg::TIME_W-1:0]      gap;
	logic                             new_leader;

	// result register
	logic                             res_v_q;
	ppcc_pkg::proto_class_t           res_pclass_q;
	logic                             res_cls_q;
	ppcc_pkg::traffic_class_t         res_tclass_q;
	ppcc_pkg::traffic_class_t         res_dom_q;
	logic [ppcc_pkg::CNT_W-1:0]       res_total_q;
	logic [ppcc_pkg::CNT_W-1:0]       res_ccnt_q;

	// apb register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite
		&& (paddr[ppcc_pkg::APB_ADDR_W-1:2] == ppcc_pkg::REG_CLASSIFY_EN);
	assign prdata = (paddr[ppcc_pkg::APB_ADDR_W-1:2] == ppcc_pkg::REG_CLASSIFY_EN)
		? {{(ppcc_pkg::APB_DATA_W-1){1'b0}}, cls_en_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cls_en_q <= 1'b1;
		end else if (cfg_wr) begin
			cls_en_q <= pwdata[0];
		end
	end

	// handshake
	assign adv       = !res_v_q || res.ready;
	assign pkt.ready = !s1_v_q || adv;
	assign accept    = pkt.valid && pkt.ready;
	assign fire      = s1_v_q && adv;

	// protocol and port classification ahead of the input register
	assign ipv4_in = (pkt.ether_type == ppcc_pkg::ETH_IPV4);
	assign src_cls = ppcc_pkg::port_lookup(pkt.source_port);
	assign dst_cls = ppcc_pkg::port_lookup(pkt.dest_port);

	always_comb begin
		if (!ipv4_in) begin
			pclass_in = ppcc_pkg::PC_NONE;
		end else if (pkt.ip_proto == ppcc_pkg::PROTO_TCP) begin
			pclass_in = ppcc_pkg::PC_TCP;
		end else if (pkt.ip_proto == ppcc_pkg::PROTO_UDP) begin
			pclass_in = ppcc_pkg::PC_UDP;
		end else if (pkt.ip_proto == ppcc_pkg::PROTO_ICMP) begin
			pclass_in = ppcc_pkg::PC_ICMP;
		end else begin
			pclass_in = ppcc_pkg::PC_OTHER;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (accept) begin
			s1_v_q <= 1'b1;
		end else if (adv) begin
			s1_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ipv4_s1   <= ipv4_in;
			pclass_s1 <= pclass_in;
			do_cls_s1 <= cls_en_q && ((pclass_in == ppcc_pkg::PC_TCP)
				|| (pclass_in == ppcc_pkg::PC_UDP));
			tclass_s1 <= (src_cls != ppcc_pkg::TC_UNKNOWN) ? src_cls : dst_cls;
			flen_s1   <= pkt.frame_length;
			time_s1   <= pkt.arrival_time;
		end
	end

	// update stage
	assign pkts_nxt    = pkts_q + 1'b1;
	assign gap         = time_s1 - prev_time_q;
	assign cls_cnt_nxt = cls_pkts_q[tclass_s1] + 1'b1;
	assign new_leader  = cls_cnt_nxt > leader_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkts_q        <= '0;
			bytes_q       <= '0;
			prev_time_q   <= '0;
			gap_total_q   <= '0;
			gap_samples_q <= '0;
			leader_cnt_q  <= '0;
			leader_cls_q  <= ppcc_pkg::TC_UNKNOWN;
			for (int i = 0; i < ppcc_pkg::NUM_PROTO; i++) begin
				proto_cnt_q[i] <= '0;
			end
			for (int i = 0; i < ppcc_pkg::NUM_CLASSES; i++) begin
				cls_pkts_q[i]  <= '0;
				cls_bytes_q[i] <= '0;
			end
		end else if (fire) begin
			pkts_q      <= pkts_nxt;
			bytes_q     <= bytes_q + ppcc_pkg::BYTE_W'(flen_s1);
			prev_time_q <= time_s1;
			if (pkts_nxt > ppcc_pkg::CNT_W'(1)) begin
				gap_total_q   <= gap_total_q + ppcc_pkg::BYTE_W'(gap);
				gap_samples_q <= gap_samples_q + 1'b1;
			end
			if (ipv4_s1) begin
				proto_cnt_q[pclass_s1[1:0]] <= proto_cnt_q[pclass_s1[1:0]] + 1'b1;
			end
			if (do_cls_s1) begin
				cls_pkts_q[tclass_s1]  <= cls_cnt_nxt;
				cls_bytes_q[tclass_s1] <= cls_bytes_q[tclass_s1]
					+ ppcc_pkg::BYTE_W'(flen_s1);
				if (new_leader) begin
					leader_cnt_q <= cls_cnt_nxt;
					leader_cls_q <= tclass_s1;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
		end else if (adv) begin
			res_v_q <= s1_v_q;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_pclass_q <= pclass_s1;
			res_cls_q    <= do_cls_s1;
			res_tclass_q <= do_cls_s1 ? tclass_s1 : ppcc_pkg::TC_UNKNOWN;
			res_dom_q    <= (do_cls_s1 && new_leader) ? tclass_s1 : leader_cls_q;
			res_total_q  <= pkts_nxt;
			res_ccnt_q   <= do_cls_s1 ? cls_cnt_nxt : '0;
		end
	end

	assign res.valid              = res_v_q;
	assign res.proto_class        = res_pclass_q;
	assign res.classified         = res_cls_q;
	assign res.traffic_class      = res_tclass_q;
	assign res.dominant_class     = res_dom_q;
	assign res.total_packet_count = res_total_q;
	assign res.class_packet_count = res_ccnt_q;

`ifndef SYNTHESIS
	a_cls_is_tcp_udp: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.classified |->
		(res.proto_class == ppcc_pkg::PC_TCP || res.proto_class == ppcc_pkg::PC_UDP))
		else $error("classified item without tcp or udp");

	a_uncls_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.classified |->
		(res.traffic_class == '0 && res.class_packet_count == '0))
		else $error("unclassified item carries a type or count");

	a_pkt_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> pkts_q == $past(pkts_q) + 1'b1)
		else $error("packet counter did not advance by one");

	a_leader_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		leader_cnt_q >= $past(leader_cnt_q))
		else $error("leader count decreased");

	a_leader_covers: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.classified |-> leader_cnt_q >= res.class_packet_count)
		else $error("class count above leader count");
`endif

endmodule
